// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/adq_pkg.sv -----
// Types and constants for the array double-ended queue unit.
package adq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int CAP_W     = 5;
    localparam int COUNT_W   = 5;
    localparam int APB_DW    = 32;
    localparam int ADDR_W    = 1;

    localparam logic [CAP_W-1:0]  CAP_RESET    = 5'd16;
    localparam logic [ADDR_W-1:0] REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        OP_PUSH_REAR  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_REAR   = 2'd2,
        OP_POP_FRONT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_ROOM = 2'd1,
        ST_EMPTY   = 2'd2
    } t_status;

    typedef struct packed {
        t_op                      opcode;
        logic signed [DATA_W-1:0] push_value;
    } t_cmd;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] popped_value;
        logic [COUNT_W-1:0]       entry_count;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_RESP
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_pop;
    } t_ctl_cmd;

    typedef struct packed {
        logic pop_ok;
    } t_dp_status;

endpackage

// ----- rtl/adq_ram.sv -----
// Generic simple dual-port RAM with registered read.
module adq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/adq_ctrl.sv -----
// Controller state machine for the deque unit.
module adq_ctrl
    import adq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_ctl_cmd   o_cmd,
    output logic       o_busy,
    output logic       o_valid
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_start && ((r_state == S_IDLE) || (r_state == S_RESP));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        unique case (r_state)
            S_IDLE, S_RESP: n_state = accept ? S_EXEC : S_IDLE;
            S_EXEC:         n_state = i_status.pop_ok ? S_READ : S_RESP;
            S_READ:         n_state = S_RESP;
            default:        n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.capture  = accept;
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.load_pop = (r_state == S_READ);
        o_busy         = (r_state == S_EXEC) || (r_state == S_READ);
        o_valid        = (r_state == S_RESP);
    end

endmodule

// ----- rtl/adq_datapath.sv -----
// Datapath: marks, slot memory and result register of the deque unit.
module adq_datapath
    import adq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctl_cmd         i_ctl,
    output t_dp_status       o_status,
    input  t_cmd             i_cmd,
    input  logic [CAP_W-1:0] i_capacity,
    input  logic             i_clear,
    output t_result          o_result
);

    localparam int MW    = $clog2(DEPTH + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int CMP_W = (MW > CAP_W) ? MW : CAP_W;

    t_cmd            r_cmd;
    logic [MW-1:0]   r_front;
    logic [MW-1:0]   r_rear;
    logic [MW-1:0]   n_front;
    logic [MW-1:0]   n_rear;
    t_result         r_result;
    t_status         st;
    logic            full;
    logic            empty;
    logic            ram_we;
    logic            ram_re;
    logic [MW-1:0]   addr;
    logic [DATA_W-1:0] ram_rdata;

    assign full  = (CMP_W'(r_rear) >= CMP_W'(i_capacity)) || (r_rear == MW'(DEPTH));
    assign empty = (r_rear <= r_front);

    always_comb begin
        n_front = r_front;
        n_rear  = r_rear;
        st      = ST_DONE;
        ram_we  = 1'b0;
        ram_re  = 1'b0;
        addr    = r_rear;
        unique case (r_cmd.opcode)
            OP_PUSH_REAR: begin
                if (full) begin
                    st = ST_NO_ROOM;
                end else begin
                    ram_we = 1'b1;
                    addr   = r_rear;
                    n_rear = r_rear + MW'(1);
                end
            end
            OP_PUSH_FRONT: begin
                if (r_front == '0) begin
                    st = ST_NO_ROOM;
                end else begin
                    ram_we  = 1'b1;
                    addr    = r_front - MW'(1);
                    n_front = r_front - MW'(1);
                end
            end
            OP_POP_REAR: begin
                if (empty) begin
                    st = ST_EMPTY;
                end else begin
                    ram_re = 1'b1;
                    addr   = r_rear - MW'(1);
                    n_rear = r_rear - MW'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    st = ST_EMPTY;
                end else begin
                    ram_re  = 1'b1;
                    addr    = r_front;
                    n_front = r_front + MW'(1);
                end
            end
            default: st = ST_DONE;
        endcase
    end

    assign o_status.pop_ok = ram_re;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_rear  <= '0;
        end else if (i_clear) begin
            r_front <= '0;
            r_rear  <= '0;
        end else if (i_ctl.exec) begin
            r_front <= n_front;
            r_rear  <= n_rear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd <= i_cmd;
        end
        if (i_ctl.exec) begin
            r_result.status       <= st;
            r_result.popped_value <= '0;
            r_result.entry_count  <= COUNT_W'(n_rear - n_front);
        end
        if (i_ctl.load_pop) begin
            r_result.popped_value <= $signed(ram_rdata);
        end
    end

    adq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we && i_ctl.exec),
        .i_waddr (addr[AW-1:0]),
        .i_wdata (r_cmd.push_value),
        .i_re    (ram_re && i_ctl.exec),
        .i_raddr (addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_result = r_result;

endmodule

// ----- rtl/array_double_ended_queue_unit.sv -----
// Top level of the array double-ended queue unit.
//
//  channel   handshake                       payload
//  -------   -----------------------------   ---------------------------------
//  request   start high while busy low       i_cmd (opcode, push_value)
//  result    o_valid, one cycle, no stall    o_result (status, popped, count)
//  config    APB write, psel/penable/pwrite  capacity at byte address 0
//
// A push or a failed operation passes through EXEC and shows its result in RESP;
// a successful pop also passes through READ between them, for the slot memory's
// registered read. A new item is taken in the cycle its predecessor's result
// is shown. Reset empties the deque and sets capacity to 16; no clearing pass.
// A capacity write also empties the deque.
`include "assert_macros.svh"

module array_double_ended_queue_unit
    import adq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_cmd              i_cmd,
    output logic              o_valid,
    output t_result           o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [CAP_W-1:0] r_capacity;
    logic             cfg_write;
    t_ctl_cmd         ctl;
    t_dp_status       dp_status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_CAPACITY);
    assign prdata    = (paddr == REG_CAPACITY) ? APB_DW'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_write) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    adq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (ctl),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    adq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .o_status   (dp_status),
        .i_cmd      (i_cmd),
        .i_capacity (r_capacity),
        .i_clear    (cfg_write),
        .o_result   (o_result)
    );

    `ASSERT_IMPLIES(a_no_result_while_busy, i_clk, i_rst_n, o_valid, !busy)
    `ASSERT_NEXT(a_accept_sets_busy, i_clk, i_rst_n, start && !busy, busy && !o_valid)
    `ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid)
    `ASSERT_IMPLIES(a_fail_pops_zero, i_clk, i_rst_n, o_valid && (o_result.status != ST_DONE), o_result.popped_value == '0)

endmodule

// ----- sim/array_double_ended_queue_unit_tb.sv -----
// Self-checking testbench for the array double-ended queue unit.
`timescale 1ns / 1ps

module array_double_ended_queue_unit_tb;
    import adq_pkg::*;

    localparam int SLOTS    = DEPTH_DEF;
    localparam int LIMIT    = 200000;
    localparam int N_ROWS   = 26;
    localparam int PHASE_N  = 235;

    typedef struct packed {
        logic               is_cfg;
        logic [CAP_W-1:0]   cfg_val;
        t_op                op;
        logic [DATA_W-1:0]  val;
        logic               typed;
        t_status            st;
        logic [DATA_W-1:0]  pop;
        logic [COUNT_W-1:0] cnt;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_cmd              i_cmd;
    logic              o_valid;
    t_result           o_result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    logic [DATA_W-1:0] slot_copy [SLOTS];
    int                front_idx;
    int                rear_idx;
    logic [CAP_W-1:0]  cap_setting;

    t_result awaited_results [$];
    t_result want_res;
    int      errors = 0;
    int      cycles = 0;
    bit      start_hi;

    t_row dir_rows [N_ROWS] = '{
        '{1'b0, 5'd0, OP_POP_REAR,   32'h0,        1'b1, ST_EMPTY,   32'h0, 5'd0},
        '{1'b0, 5'd0, OP_POP_FRONT,  32'h0,        1'b1, ST_EMPTY,   32'h0, 5'd0},
        '{1'b0, 5'd0, OP_PUSH_FRONT, 32'h5,        1'b1, ST_NO_ROOM, 32'h0, 5'd0},
        '{1'b0, 5'd0, OP_PUSH_REAR,  32'h7fffffff, 1'b1, ST_DONE,    32'h0, 5'd1},
        '{1'b0, 5'd0, OP_PUSH_REAR,  32'h80000000, 1'b1, ST_DONE,    32'h0, 5'd2},
        '{1'b0, 5'd0, OP_PUSH_REAR,  32'h0,        1'b0, ST_DONE,    32'h0, 5'd0},
        '{1'b0, 5'd0, OP_PUSH_REAR,  32'hffffffff, 1'b0, ST_DONE,    32'h0, 5'd0},
        '{1'b0, 5'd0, OP_POP_FRONT,  32'h0,        1'b0, ST_DONE,    32'h0, 5'd0},
        '{1'b0, 5'd0, OP_POP_FRONT,  32'h0,        1'b0, ST_DONE,    32'h0, 5'd0},
        '{1'b0, 5'd0, OP_PUSH_FRONT, 32'h55555555, 1'b0, ST_DONE,    32'h0, 5'd0},
        '{1'b0, 5'd0, OP_PUSH_FRONT, 32'haaaaaaaa, 1'b0, ST_DONE,    32'h0, 5'd0},
        '{1'b0, 5'd0, OP_PUSH_FRONT, 32'h1,        1'b0, ST_DONE,    32'h0, 5'd0},
        '{1'b0, 5'd0, OP_POP_REAR,   32'h0,        1'b0, ST_DONE,    32'h0, 5'd0},
        '{1'b0, 5'd0, OP_POP_REAR,   32'h0,        1'b0, ST_DONE,    32'h0, 5'd0},
        '{1'b0, 5'd0, OP_POP_FRONT,  32'h0,        1'b0, ST_DONE,    32'h0, 5'd0},
        '{1'b0, 5'd0, OP_POP_FRONT,  32'h0,        1'b0, ST_DONE,    32'h0, 5'd0},
        '{1'b0, 5'd0, OP_POP_FRONT,  32'h0,        1'b0, ST_DONE,    32'h0, 5'd0},
        '{1'b1, 5'd1, OP_PUSH_REAR,  32'h0,        1'b0, ST_DONE,    32'h0, 5'd0},
        '{1'b0, 5'd0, OP_PUSH_REAR,  32'h12345678, 1'b1, ST_DONE,    32'h0, 5'd1},
        '{1'b0, 5'd0, OP_PUSH_REAR,  32'h9,        1'b1, ST_NO_ROOM, 32'h0, 5'd1},
        '{1'b0, 5'd0, OP_POP_REAR,   32'h0,        1'b0, ST_DONE,    32'h0, 5'd0},
        '{1'b1, 5'd0, OP_PUSH_REAR,  32'h0,        1'b0, ST_DONE,    32'h0, 5'd0},
        '{1'b0, 5'd0, OP_PUSH_REAR,  32'h3,        1'b1, ST_NO_ROOM, 32'h0, 5'd0},
        '{1'b0, 5'd0, OP_PUSH_FRONT, 32'h3,        1'b1, ST_NO_ROOM, 32'h0, 5'd0},
        '{1'b1, 5'd31, OP_PUSH_REAR, 32'h0,        1'b0, ST_DONE,    32'h0, 5'd0},
        '{1'b1, 5'd16, OP_PUSH_REAR, 32'h0,        1'b0, ST_DONE,    32'h0, 5'd0}
    };

    array_double_ended_queue_unit #(
        .DEPTH(SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .o_result(o_result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_result apply_request(input t_cmd c);
        t_result r;
        int      room;
        room = (cap_setting > SLOTS) ? SLOTS : int'(cap_setting);
        r.status = ST_DONE;
        r.popped_value = '0;
        case (c.opcode)
            OP_PUSH_REAR: begin
                if (rear_idx >= room) begin
                    r.status = ST_NO_ROOM;
                end else begin
                    slot_copy[rear_idx] = c.push_value;
                    rear_idx++;
                end
            end
            OP_PUSH_FRONT: begin
                if (front_idx == 0) begin
                    r.status = ST_NO_ROOM;
                end else begin
                    front_idx--;
                    slot_copy[front_idx] = c.push_value;
                end
            end
            OP_POP_REAR: begin
                if (rear_idx <= front_idx) begin
                    r.status = ST_EMPTY;
                end else begin
                    rear_idx--;
                    r.popped_value = slot_copy[rear_idx];
                end
            end
            default: begin
                if (rear_idx <= front_idx) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped_value = slot_copy[front_idx];
                    front_idx++;
                end
            end
        endcase
        r.entry_count = COUNT_W'(rear_idx - front_idx);
        return r;
    endfunction

    task automatic send_cmd(input t_cmd c, input int gap, input logic typed,
                            input t_result typed_res);
        t_result r;
        if (!start_hi) start <= 1'b1;
        start_hi = 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        r = apply_request(c);
        awaited_results.push_back(typed ? typed_res : r);
        if (gap > 0) begin
            start <= 1'b0;
            start_hi = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        if (start_hi) begin
            start <= 1'b0;
            start_hi = 1'b0;
            @(posedge i_clk);
        end
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_CAPACITY;
        pwdata  <= APB_DW'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cap_setting = v;
        front_idx   = 0;
        rear_idx    = 0;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DW'(v)) begin
            $error("capacity readback expected %0d actual %0d", v, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (awaited_results.size() == 0) begin
                $error("result arrived with none awaited");
                errors++;
            end else begin
                want_res = awaited_results.pop_front();
                if (o_result.status !== want_res.status) begin
                    $error("status expected %0d actual %0d",
                           want_res.status, o_result.status);
                    errors++;
                end
                if (o_result.popped_value !== want_res.popped_value) begin
                    $error("popped_value expected %h actual %h",
                           want_res.popped_value, o_result.popped_value);
                    errors++;
                end
                if (o_result.entry_count !== want_res.entry_count) begin
                    $error("entry_count expected %0d actual %0d",
                           want_res.entry_count, o_result.entry_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_cmd    c;
        t_result tr;
        int      push_pct;
        int      idle_pct;
        int      gap;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_cmd   <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        cap_setting = CAP_RESET;
        front_idx   = 0;
        rear_idx    = 0;
        start_hi    = 1'b0;
        push_pct    = 50;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < N_ROWS; n++) begin
            if (dir_rows[n].is_cfg) begin
                write_capacity(dir_rows[n].cfg_val);
            end else begin
                c.opcode     = dir_rows[n].op;
                c.push_value = dir_rows[n].val;
                tr = '{dir_rows[n].st, dir_rows[n].pop, dir_rows[n].cnt};
                send_cmd(c, $urandom_range(1), dir_rows[n].typed, tr);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: idle_pct = 0;
                1: begin
                    idle_pct = 74;
                    write_capacity(CAP_W'($urandom_range(8, 2)));
                end
                2: begin
                    idle_pct = 0;
                    write_capacity(5'd31);
                end
                default: begin
                    idle_pct = 31;
                    write_capacity(CAP_W'($urandom_range(16, 1)));
                end
            endcase
            for (int k = 0; k < PHASE_N; k++) begin
                if (k % 16 == 0) begin
                    case ($urandom_range(2))
                        0: push_pct = 15;
                        1: push_pct = 50;
                        default: push_pct = 85;
                    endcase
                end
                // hold off until every result is in
                if (k % 100 == 99) drain();
                if ($urandom_range(99) < push_pct)
                    c.opcode = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
                else
                    c.opcode = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
                if ($urandom_range(7) == 0) begin
                    case ($urandom_range(3))
                        0: c.push_value = 32'h0;
                        1: c.push_value = 32'hffffffff;
                        2: c.push_value = 32'h7fffffff;
                        default: c.push_value = 32'h80000000;
                    endcase
                end else begin
                    c.push_value = $urandom;
                end
                gap = ($urandom_range(99) < idle_pct) ? $urandom_range(6, 1) : 0;
                send_cmd(c, gap, 1'b0, tr);
            end
        end

        drain();
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/adq_pkg.sv
rtl/adq_ram.sv
rtl/adq_ctrl.sv
rtl/adq_datapath.sv
rtl/array_double_ended_queue_unit.sv
sim/array_double_ended_queue_unit_tb.sv
